// ----- hdl/plc_pkg.sv -----
`default_nettype none
package plc_pkg;

   localparam int SAMPLE_W    = 17;
   localparam int FRAC_W      = 17;
   localparam int DIV_STAGES  = 17;
   localparam int LERP_STAGES = 5;
   localparam int SEG_COUNT   = 5;
   localparam int CHANNELS    = 3;
   localparam int T_W         = 22;
   localparam int RECIP_SHIFT = 22;

   localparam logic [15:0] FULL_SCALE_RESET = 16'd1200;

   typedef logic [2:0] seg_idx_type;
   typedef logic [7:0] color_type;

   // upper breakpoints, Q0.16; last segment runs to one
   localparam logic [15:0] SEG_HI [SEG_COUNT-1] = '{
      16'd21845, 16'd30802, 16'd42271, 16'd51839
   };

   localparam logic [15:0] SEG_LO [SEG_COUNT] = '{
      16'd0, 16'd21845, 16'd30802, 16'd42271, 16'd51839
   };

   localparam logic [14:0] SEG_DEN [SEG_COUNT] = '{
      15'd21845, 15'd8957, 15'd11469, 15'd9568, 15'd13697
   };

   // floor(2^22 / den)
   localparam logic [8:0] SEG_RECIP [SEG_COUNT] = '{
      9'd192, 9'd468, 9'd365, 9'd438, 9'd306
   };

   localparam color_type SEG_START [SEG_COUNT][CHANNELS] = '{
      '{8'd22,  8'd30,  8'd151},
      '{8'd0,   8'd181, 8'd226},
      '{8'd76,  8'd140, 8'd43},
      '{8'd0,   8'd206, 8'd24},
      '{8'd254, 8'd209, 8'd65}
   };

   // |end - start| per channel
   localparam color_type SEG_MAG [SEG_COUNT][CHANNELS] = '{
      '{8'd22,  8'd151, 8'd75},
      '{8'd76,  8'd41,  8'd183},
      '{8'd76,  8'd66,  8'd19},
      '{8'd254, 8'd3,   8'd41},
      '{8'd1,   8'd209, 8'd65}
   };

   // bit c set: channel c falls across the segment
   localparam logic [CHANNELS-1:0] SEG_FALL [SEG_COUNT] = '{
      3'b001, 3'b110, 3'b101, 3'b000, 3'b110
   };

endpackage
`default_nettype wire

// ----- hdl/plc_div.sv -----
`default_nettype none
module plc_div import plc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire logic [15:0]       in_num,
   input  wire logic [15:0]       in_den,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output logic [FRAC_W-1:0]      out_frac
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [DIV_STAGES-1:0] adv;
   logic [15:0]           rem_ff [DIV_STAGES];
   logic [15:0]           rem_in [DIV_STAGES];
   logic [FRAC_W-1:0]     quo_ff [DIV_STAGES];
   logic [FRAC_W-1:0]     quo_in [DIV_STAGES];

   always_comb begin
      logic down_en;
      down_en = !out_stall;
      for (int i = DIV_STAGES - 1; i >= 0; i--) begin
         adv[i]  = !valid_ff[i] || down_en;
         down_en = adv[i];
      end
   end

   // one quotient bit per stage; numerator never exceeds divisor
   always_comb begin
      logic [16:0] twice;
      logic        ge;
      logic        top_bit;
      top_bit   = (in_num >= in_den);
      valid_in[0] = in_valid;
      rem_in[0] = top_bit ? (in_num - in_den) : in_num;
      quo_in[0] = {{(FRAC_W-1){1'b0}}, top_bit};
      for (int i = 1; i < DIV_STAGES; i++) begin
         twice       = {rem_ff[i-1], 1'b0};
         ge          = (twice >= {1'b0, in_den});
         valid_in[i] = valid_ff[i-1];
         rem_in[i]   = ge ? 16'(twice - {1'b0, in_den}) : twice[15:0];
         quo_in[i]   = {quo_ff[i-1][FRAC_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (adv[i]) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_frac  = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/plc_lerp.sv -----
`default_nettype none
module plc_lerp import plc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire logic [FRAC_W-1:0] in_frac,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output color_type              out_red,
   output color_type              out_green,
   output color_type              out_blue
);

   logic [LERP_STAGES-1:0] valid_ff;
   logic [LERP_STAGES-1:0] adv;

   seg_idx_type seg0_ff, seg0_in;
   logic [14:0] df0_ff, df0_in;

   seg_idx_type    seg1_ff;
   logic [T_W-1:0] t1_ff [CHANNELS];
   logic [T_W-1:0] t1_in [CHANNELS];

   seg_idx_type    seg2_ff;
   logic [T_W-1:0] t2_ff [CHANNELS];
   color_type      qe2_ff [CHANNELS];
   color_type      qe2_in [CHANNELS];

   seg_idx_type seg3_ff;
   logic [15:0] rem3_ff [CHANNELS];
   logic [15:0] rem3_in [CHANNELS];
   color_type   qe3_ff [CHANNELS];

   color_type   col_ff [CHANNELS];
   color_type   col_in [CHANNELS];

   always_comb begin
      logic down_en;
      down_en = !out_stall;
      for (int i = LERP_STAGES - 1; i >= 0; i--) begin
         adv[i]  = !valid_ff[i] || down_en;
         down_en = adv[i];
      end
   end

   // segment select, breakpoint goes to the lower segment
   always_comb begin
      logic [FRAC_W-1:0] diff;
      seg0_in = seg_idx_type'(SEG_COUNT - 1);
      for (int j = SEG_COUNT - 2; j >= 0; j--) begin
         if (in_frac <= {1'b0, SEG_HI[j]}) begin
            seg0_in = seg_idx_type'(j);
         end
      end
      diff   = in_frac - {1'b0, SEG_LO[seg0_in]};
      df0_in = diff[14:0];
   end

   always_comb begin
      logic [22:0] prod_t;
      logic [30:0] prod_q;
      logic [22:0] prod_m;
      logic [21:0] diff;
      for (int c = 0; c < CHANNELS; c++) begin
         prod_t     = 23'(df0_ff) * 23'(SEG_MAG[seg0_ff][c]);
         t1_in[c]   = prod_t[T_W-1:0];
         prod_q     = 31'(t1_ff[c]) * 31'(SEG_RECIP[seg1_ff]);
         qe2_in[c]  = prod_q[RECIP_SHIFT+7:RECIP_SHIFT];
         prod_m     = 23'(qe2_ff[c]) * 23'(SEG_DEN[seg2_ff]);
         diff       = t2_ff[c] - prod_m[T_W-1:0];
         rem3_in[c] = diff[15:0];
      end
   end

   // quotient estimate is low by at most one
   always_comb begin
      logic      ge;
      logic      nz;
      color_type q;
      for (int c = 0; c < CHANNELS; c++) begin
         ge = (rem3_ff[c] >= {1'b0, SEG_DEN[seg3_ff]});
         nz = ge ? (rem3_ff[c] != {1'b0, SEG_DEN[seg3_ff]}) : (rem3_ff[c] != 16'd0);
         q  = qe3_ff[c] + color_type'(ge);
         if (SEG_FALL[seg3_ff][c]) begin
            col_in[c] = SEG_START[seg3_ff][c] - q - color_type'(nz);
         end else begin
            col_in[c] = SEG_START[seg3_ff][c] + q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < LERP_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         seg0_ff <= seg0_in;
         df0_ff  <= df0_in;
      end
      if (adv[1]) begin
         seg1_ff <= seg0_ff;
         t1_ff   <= t1_in;
      end
      if (adv[2]) begin
         seg2_ff <= seg1_ff;
         t2_ff   <= t1_ff;
         qe2_ff  <= qe2_in;
      end
      if (adv[3]) begin
         seg3_ff <= seg2_ff;
         rem3_ff <= rem3_in;
         qe3_ff  <= qe2_ff;
      end
      if (adv[4]) begin
         col_ff <= col_in;
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[LERP_STAGES-1];
   assign out_red   = col_ff[0];
   assign out_green = col_ff[1];
   assign out_blue  = col_ff[2];

endmodule
`default_nettype wire

// ----- hdl/piecewise_linear_colormap_core.sv -----
// Pipeline: 1 clamp stage, 17 divider stages at one quotient bit each and
// 5 lerp stages. Throughput: one beat per cycle while rsp_stall is low;
// any stage holding a bubble keeps accepting.
// Reset: synchronous, active high; empties the pipeline and sets
// full_scale to 1200.
`default_nettype none
module piecewise_linear_colormap_core import plc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [15:0]         csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample_delta,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output color_type                rsp_red,
   output color_type                rsp_green,
   output color_type                rsp_blue
);

   logic [15:0] full_scale_ff;
   logic [15:0] scale_eff;
   logic        clamp_valid_ff;
   logic [15:0] clamp_ff, clamp_in;
   logic        clamp_adv;
   logic        div_stall;
   logic        div_valid;
   logic        lerp_stall;
   logic [FRAC_W-1:0] div_frac;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_write_enable) begin
         full_scale_ff <= csr_write_data;
      end
   end

   assign scale_eff = (full_scale_ff == 16'd0) ? 16'd1 : full_scale_ff;
   assign clamp_adv = !clamp_valid_ff || !div_stall;
   assign req_stall = !clamp_adv;

   always_comb begin
      if (req_sample_delta[SAMPLE_W-1]) begin
         clamp_in = 16'd0;
      end else if (req_sample_delta[15:0] > scale_eff) begin
         clamp_in = scale_eff;
      end else begin
         clamp_in = req_sample_delta[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_valid_ff <= 1'b0;
      end else if (clamp_adv) begin
         clamp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (clamp_adv) begin
         clamp_ff <= clamp_in;
      end
   end

   plc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (clamp_valid_ff),
      .in_stall  (div_stall),
      .in_num    (clamp_ff),
      .in_den    (scale_eff),
      .out_valid (div_valid),
      .out_stall (lerp_stall),
      .out_frac  (div_frac)
   );

   plc_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_stall  (lerp_stall),
      .in_frac   (div_frac),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule
`default_nettype wire

// ----- hdl/plc_checker.sv -----
`default_nettype none
module plc_checker import plc_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire color_type           rsp_red,
   input wire color_type           rsp_green,
   input wire color_type           rsp_blue
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable({rsp_red, rsp_green, rsp_blue}))
      else $error("response payload changed while stalled");

   // free-running output means every stage advances
   a_no_stall_through: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("request stalled with response side open");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind piecewise_linear_colormap_core plc_checker u_checker (.*);
`default_nettype wire

// ----- dv/piecewise_linear_colormap_core_test.sv -----
`timescale 1ns / 100ps
module piecewise_linear_colormap_core_test;
   import plc_pkg::*;

   localparam int IDLE_PCT    = 34;
   localparam int HOLD_AT     = 250;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 94;

   // Q0.16 segment ends and end colors
   localparam int SEG_FROM [5] = '{0, 21845, 30802, 42271, 51839};
   localparam int SEG_TO   [5] = '{21845, 30802, 42271, 51839, 65536};
   localparam int COLOR_FROM [5][3] = '{
      '{22, 30, 151}, '{0, 181, 226}, '{76, 140, 43}, '{0, 206, 24}, '{254, 209, 65}
   };
   localparam int COLOR_TO [5][3] = '{
      '{0, 181, 226}, '{76, 140, 43}, '{0, 206, 24}, '{254, 209, 65}, '{255, 0, 0}
   };

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
   } pixel_t;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [15:0]         csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_delta = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   color_type           rsp_red;
   color_type           rsp_green;
   color_type           rsp_blue;

   logic [SAMPLE_W-1:0] pending_samples [$];
   pixel_t              expected_pixels [$];
   logic [15:0]         full_scale_model = FULL_SCALE_RESET;
   int                  in_flight        = 0;
   int                  error_count      = 0;
   int                  rsp_count        = 0;
   bit                  steady           = 1'b0;
   bit                  hold_used        = 1'b0;
   int                  hold_left        = 0;

   piecewise_linear_colormap_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_delta (req_sample_delta),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue)
   );

   always #6 clock = ~clock;

   function automatic pixel_t map_sample(logic [SAMPLE_W-1:0] raw, logic [15:0] fs_reg);
      int     v;
      longint fs;
      longint p;
      longint f;
      longint den;
      longint num;
      int     k;
      int     c [3];
      pixel_t px;
      v  = $signed(raw);
      fs = (fs_reg == 16'd0) ? 1 : longint'(fs_reg);
      if (v < 0)
         p = 0;
      else if (longint'(v) > fs)
         p = fs;
      else
         p = v;
      f = (p << 16) / fs;
      if (f > 65536)
         f = 65536;
      k = 0;
      while (k < 4 && f > SEG_TO[k])
         k++;
      den = SEG_TO[k] - SEG_FROM[k];
      for (int ch = 0; ch < 3; ch++) begin
         num = COLOR_FROM[k][ch] * den
               + (f - SEG_FROM[k]) * (COLOR_TO[k][ch] - COLOR_FROM[k][ch]);
         if (num < 0)
            num = 0;
         c[ch] = int'((num / den) & 255);
      end
      px.red   = color_type'(c[0]);
      px.green = color_type'(c[1]);
      px.blue  = color_type'(c[2]);
      return px;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(logic [15:0] fs_reg);
      int unsigned sel;
      int          fs;
      int          v;
      sel = $urandom_range(99);
      fs  = (fs_reg == 16'd0) ? 1 : int'(fs_reg);
      if (sel < 20)
         v = $urandom;
      else if (sel < 30)
         v = -int'($urandom_range(40, 1));
      else if (sel < 40)
         v = fs + int'($urandom_range(40));
      else
         v = $urandom_range(fs);
      return SAMPLE_W'(v);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_pixels.push_back(map_sample(req_sample_delta, full_scale_model));
         if (!(req_valid && req_stall)) begin
            if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_sample_delta <= pending_samples.pop_front();
               req_valid        <= 1'b1;
               in_flight++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      pixel_t want;
      bit     stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected response beat: red %0d green %0d blue %0d",
                      rsp_red, rsp_green, rsp_blue);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               in_flight--;
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, rsp_red);
                  error_count++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, rsp_green);
                  error_count++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, rsp_blue);
                  error_count++;
               end
            end
         end
         if (!hold_used && rsp_count == HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = !steady && ($urandom_range(99) < IDLE_PCT);
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic write_full_scale(logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      full_scale_model = value;
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || in_flight != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      logic [15:0] fs_list [8];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset scale: clamps both ways and the breakpoint neighborhoods
      pending_samples = '{17'h10000, 17'h1FFFF, 17'd0, 17'd1, 17'd399, 17'd400,
                          17'd1199, 17'd1200, 17'd1201, 17'h0FFFF};
      drain();

      // f equals p here, so breakpoints are hit exactly
      write_full_scale(16'd65535);
      pending_samples = '{17'd21845, 17'd21846, 17'd30802, 17'd30803, 17'd42271,
                          17'd42272, 17'd51839, 17'd51840, 17'd65534};
      drain();

      write_full_scale(16'd3);
      pending_samples = '{17'd1, 17'd2, 17'd3};
      drain();

      // zero scale acts as one
      write_full_scale(16'd0);
      pending_samples = '{17'd0, 17'd1, 17'd5};
      drain();

      fs_list = '{16'd1200, 16'd1, 16'd65535, 16'd2, 16'($urandom_range(65535, 1)),
                  16'($urandom_range(2000, 3)), 16'd0, 16'($urandom)};
      for (int ph = 0; ph < 8; ph++) begin
         write_full_scale(fs_list[ph]);
         steady = (ph == 2);
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_samples.push_back(pick_sample(fs_list[ph]));
         drain();
      end
      steady = 1'b0;

      repeat (30) @(posedge clock);
      if (error_count == 0 && expected_pixels.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
